// File: rtl/core/assert_macros.svh
// Assertion macros for the RTL files.
// Both expect signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Consequent must hold in the cycle after the antecedent.
`define PPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/core/ppd_pkg.sv
`default_nettype none
package ppd_pkg;

  // Fixed field widths of the item formats.
  localparam int COORD_WIDTH = 24;
  localparam int INDEX_WIDTH = 6;
  localparam int COUNT_WIDTH = 7;
  localparam int DIST_WIDTH  = 25;

  // Datapath widths derived from the coordinate width.
  localparam int DIFF_WIDTH = COORD_WIDTH + 1;
  localparam int MUL_WIDTH  = COORD_WIDTH + 3;
  localparam int PROD_WIDTH = 2 * MUL_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 1;
  localparam int SQRT_STEPS = (ACC_WIDTH + 1) / 2;

  // Defaults for the top-level parameters.
  localparam int DEF_MAX_VERTICES = 64;
  localparam int DEF_FRAC_BITS    = 16;

  // Command codes.
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                          command;
    logic [INDEX_WIDTH-1:0]        vertex_index;
    logic                          new_polyline;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
  } in_item_t;

  typedef struct packed {
    logic [DIST_WIDTH-1:0] distance;
    logic                  found;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/core/point_polyline_distance_unit.sv
// A load transaction writes the vertex memory in the accepting cycle; the unit stays ready.
// A query reads the first vertex, then for each segment reads its end, forms the dot product and
// length squared, and either clamps to an end or divides for FracBits quotient bits and scales;
// breaks are skipped. The bit-serial root follows, skipped with no segment found or under two vertices.
// One query is in work at a time; a stalled output adds its stall. Synchronous active-low
// reset clears the sequencer, the vertex count and the output valid, not the vertex memory.
`default_nettype none
`include "assert_macros.svh"
module point_polyline_distance_unit
  import ppd_pkg::*;
#(
  parameter int MaxVertices = DEF_MAX_VERTICES,
  parameter int FracBits    = DEF_FRAC_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire in_item_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output out_item_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [COUNT_WIDTH-1:0] cfg_data
);

  localparam int AddrWidth   = (MaxVertices > 1) ? $clog2(MaxVertices) : 1;
  localparam int NumWidth    = AddrWidth + 1;
  localparam int DivCntWidth = $clog2(FracBits + 1);
  localparam int WordWidth   = 1 + 2 * COORD_WIDTH;
  localparam logic [SQRT_STEPS-1:0] DistMax = SQRT_STEPS'((64'd1 << DIST_WIDTH) - 64'd1);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_RDA  = 12'b0000_0000_0010,
    S_LDA  = 12'b0000_0000_0100,
    S_RDB  = 12'b0000_0000_1000,
    S_LDB  = 12'b0000_0001_0000,
    S_MUL  = 12'b0000_0010_0000,
    S_CHK  = 12'b0000_0100_0000,
    S_DIV  = 12'b0000_1000_0000,
    S_SCL  = 12'b0001_0000_0000,
    S_SQD  = 12'b0010_0000_0000,
    S_SQRT = 12'b0100_0000_0000,
    S_DONE = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [COUNT_WIDTH-1:0]        vertex_count_r;
  logic [AddrWidth-1:0]          idx_r, idx_nxt;
  logic [NumWidth-1:0]           n_r, n_nxt;
  logic signed [COORD_WIDTH-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [COORD_WIDTH-1:0] ax_r, ax_nxt, ay_r, ay_nxt;
  logic signed [COORD_WIDTH-1:0] bx_r, bx_nxt, by_r, by_nxt;
  logic signed [DIFF_WIDTH-1:0]  ux_r, ux_nxt, uy_r, uy_nxt;
  logic signed [DIFF_WIDTH-1:0]  wx_r, wx_nxt, wy_r, wy_nxt;
  logic [2:0]                    k_r, k_nxt;
  logic signed [PROD_WIDTH-1:0]  prod_r;
  logic signed [ACC_WIDTH-1:0]   dot_r, dot_nxt, uu_r, uu_nxt;
  logic [ACC_WIDTH:0]            rem_r, rem_nxt;
  logic [FracBits-1:0]           q_r, q_nxt;
  logic [DivCntWidth-1:0]        dcnt_r, dcnt_nxt;
  logic signed [MUL_WIDTH-1:0]   dx_r, dx_nxt, dy_r, dy_nxt;
  logic [ACC_WIDTH-1:0]          best_r, best_nxt;
  logic                          found_r, found_nxt;
  logic [DIST_WIDTH-1:0]         dist_r, dist_nxt;
  logic                          out_valid_r, out_valid_nxt;
  out_item_t                     out_data_r, out_data_nxt;

  // Vertex memory: {break flag, x, y} per slot.
  logic [WordWidth-1:0]          mem [MaxVertices];
  logic [WordWidth-1:0]          mem_q_r;
  logic                          wr_en;
  logic [AddrWidth-1:0]          wr_addr;
  logic                          q_flag;
  logic signed [COORD_WIDTH-1:0] qx, qy;

  // Shared multiplier.
  logic signed [MUL_WIDTH-1:0]   opa, opb;
  logic signed [PROD_WIDTH-1:0]  prod_c;
  logic signed [MUL_WIDTH-1:0]   ux_e, uy_e, ux_abs, uy_abs;
  logic [PROD_WIDTH-1:0]         scl_mag;
  logic signed [MUL_WIDTH-1:0]   s_pos;

  // Divider step.
  logic [ACC_WIDTH:0]            rem_sh, uu_ext;
  logic                          div_ge;

  logic                          seg_last;
  logic [ACC_WIDTH-1:0]          d2;
  logic                          sqrt_start;
  logic [ACC_WIDTH-1:0]          sqrt_rad;
  logic                          sqrt_done;
  logic [SQRT_STEPS-1:0]         sqrt_root;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Loads with an index below MaxVertices write the memory in the accepting cycle.
  assign wr_en   = in_valid && in_ready && (in_data.command == CMD_LOAD) &&
                   (int'(in_data.vertex_index) < MaxVertices);
  assign wr_addr = AddrWidth'(in_data.vertex_index);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {in_data.new_polyline, in_data.coord_x, in_data.coord_y};
    end
    mem_q_r <= mem[idx_r];
  end

  assign q_flag = mem_q_r[WordWidth-1];
  assign qx     = mem_q_r[2*COORD_WIDTH-1:COORD_WIDTH];
  assign qy     = mem_q_r[COORD_WIDTH-1:0];

  // Operand selection for the shared multiplier.
  assign ux_e   = MUL_WIDTH'(ux_r);
  assign uy_e   = MUL_WIDTH'(uy_r);
  assign ux_abs = ux_e[MUL_WIDTH-1] ? -ux_e : ux_e;
  assign uy_abs = uy_e[MUL_WIDTH-1] ? -uy_e : uy_e;

  always_comb begin
    opa = '0;
    opb = '0;
    case (state_r)
      S_MUL: begin
        case (k_r)
          3'd0: begin
            opa = MUL_WIDTH'(wx_r);
            opb = ux_e;
          end
          3'd1: begin
            opa = MUL_WIDTH'(wy_r);
            opb = uy_e;
          end
          3'd2: begin
            opa = ux_e;
            opb = ux_e;
          end
          default: begin
            opa = uy_e;
            opb = uy_e;
          end
        endcase
      end
      S_SCL: begin
        opa = MUL_WIDTH'(q_r);
        opb = (k_r == 3'd0) ? ux_abs : uy_abs;
      end
      S_SQD: begin
        opa = (k_r == 3'd0) ? dx_r : dy_r;
        opb = (k_r == 3'd0) ? dx_r : dy_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  assign prod_c = opa * opb;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
  end

  // Rounded scale of the projection, ties away from zero on the magnitude.
  assign scl_mag = ($unsigned(prod_r) + (PROD_WIDTH'(1) << (FracBits - 1))) >> FracBits;
  assign s_pos   = MUL_WIDTH'(scl_mag);

  // One restoring division step per cycle.
  assign uu_ext = (ACC_WIDTH+1)'($unsigned(uu_r));
  assign rem_sh = {rem_r[ACC_WIDTH-1:0], 1'b0};
  assign div_ge = rem_sh >= uu_ext;

  assign seg_last = (NumWidth'(idx_r) + NumWidth'(1)) >= n_r;
  assign d2       = ACC_WIDTH'($unsigned(dot_r + ACC_WIDTH'(prod_r)));

  // Query sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    ux_nxt        = ux_r;
    uy_nxt        = uy_r;
    wx_nxt        = wx_r;
    wy_nxt        = wy_r;
    k_nxt         = k_r;
    dot_nxt       = dot_r;
    uu_nxt        = uu_r;
    rem_nxt       = rem_r;
    q_nxt         = q_r;
    dcnt_nxt      = dcnt_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    best_nxt      = best_r;
    found_nxt     = found_r;
    dist_nxt      = dist_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    sqrt_start    = 1'b0;
    sqrt_rad      = best_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid && (in_data.command == CMD_QUERY)) begin
          px_nxt    = in_data.coord_x;
          py_nxt    = in_data.coord_y;
          found_nxt = 1'b0;
          best_nxt  = '0;
          idx_nxt   = '0;
          if (int'(vertex_count_r) > MaxVertices) begin
            n_nxt = NumWidth'(MaxVertices);
          end else begin
            n_nxt = NumWidth'(vertex_count_r);
          end
          state_nxt = (n_nxt < NumWidth'(2)) ? S_DONE : S_RDA;
        end
      end
      S_RDA: begin
        state_nxt = S_LDA;
      end
      S_LDA: begin
        ax_nxt    = qx;
        ay_nxt    = qy;
        idx_nxt   = AddrWidth'(1);
        state_nxt = S_RDB;
      end
      S_RDB: begin
        state_nxt = S_LDB;
      end
      S_LDB: begin
        bx_nxt = qx;
        by_nxt = qy;
        ux_nxt = DIFF_WIDTH'(qx) - DIFF_WIDTH'(ax_r);
        uy_nxt = DIFF_WIDTH'(qy) - DIFF_WIDTH'(ay_r);
        wx_nxt = DIFF_WIDTH'(px_r) - DIFF_WIDTH'(ax_r);
        wy_nxt = DIFF_WIDTH'(py_r) - DIFF_WIDTH'(ay_r);
        k_nxt  = '0;
        if (q_flag) begin
          // Polyline break: no segment ends here, move on.
          ax_nxt = qx;
          ay_nxt = qy;
          if (seg_last) begin
            if (found_r) begin
              sqrt_start = 1'b1;
              state_nxt  = S_SQRT;
            end else begin
              state_nxt = S_DONE;
            end
          end else begin
            idx_nxt   = idx_r + AddrWidth'(1);
            state_nxt = S_RDB;
          end
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // Products are registered in prod_r; accumulate dot and length squared.
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd0: begin
            dot_nxt = dot_r;
          end
          3'd1: begin
            dot_nxt = ACC_WIDTH'(prod_r);
          end
          3'd2: begin
            dot_nxt = dot_r + ACC_WIDTH'(prod_r);
          end
          3'd3: begin
            uu_nxt = ACC_WIDTH'(prod_r);
          end
          default: begin
            uu_nxt    = uu_r + ACC_WIDTH'(prod_r);
            state_nxt = S_CHK;
          end
        endcase
      end
      S_CHK: begin
        k_nxt = '0;
        if ((uu_r == '0) || dot_r[ACC_WIDTH-1] || (dot_r == '0)) begin
          dx_nxt    = MUL_WIDTH'(wx_r);
          dy_nxt    = MUL_WIDTH'(wy_r);
          state_nxt = S_SQD;
        end else if (dot_r >= uu_r) begin
          dx_nxt    = MUL_WIDTH'(px_r) - MUL_WIDTH'(bx_r);
          dy_nxt    = MUL_WIDTH'(py_r) - MUL_WIDTH'(by_r);
          state_nxt = S_SQD;
        end else begin
          rem_nxt   = (ACC_WIDTH+1)'($unsigned(dot_r));
          q_nxt     = '0;
          dcnt_nxt  = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = div_ge ? (rem_sh - uu_ext) : rem_sh;
        q_nxt    = {q_r[FracBits-2:0], div_ge};
        dcnt_nxt = dcnt_r + DivCntWidth'(1);
        if (dcnt_r == DivCntWidth'(FracBits - 1)) begin
          k_nxt     = '0;
          state_nxt = S_SCL;
        end
      end
      S_SCL: begin
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd0: begin
            dx_nxt = dx_r;
          end
          3'd1: begin
            dx_nxt = MUL_WIDTH'(wx_r) - (ux_r[DIFF_WIDTH-1] ? -s_pos : s_pos);
          end
          default: begin
            dy_nxt    = MUL_WIDTH'(wy_r) - (uy_r[DIFF_WIDTH-1] ? -s_pos : s_pos);
            k_nxt     = '0;
            state_nxt = S_SQD;
          end
        endcase
      end
      S_SQD: begin
        k_nxt = k_r + 3'd1;
        case (k_r)
          3'd0: begin
            dot_nxt = dot_r;
          end
          3'd1: begin
            dot_nxt = ACC_WIDTH'(prod_r);
          end
          default: begin
            // Keep the smallest squared distance, then step to the next vertex or start the root.
            if (!found_r || (d2 < best_r)) begin
              best_nxt = d2;
            end
            found_nxt = 1'b1;
            ax_nxt    = bx_r;
            ay_nxt    = by_r;
            if (seg_last) begin
              sqrt_start = 1'b1;
              sqrt_rad   = best_nxt;
              state_nxt  = S_SQRT;
            end else begin
              idx_nxt   = idx_r + AddrWidth'(1);
              state_nxt = S_RDB;
            end
          end
        endcase
      end
      S_SQRT: begin
        if (sqrt_done) begin
          dist_nxt  = (sqrt_root > DistMax) ? DIST_WIDTH'(DistMax) : DIST_WIDTH'(sqrt_root);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt         = 1'b1;
          out_data_nxt.found    = found_r;
          out_data_nxt.distance = found_r ? dist_r : '0;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  ppd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_rad),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      out_valid_r    <= 1'b0;
      vertex_count_r <= '0;
      idx_r          <= '0;
      k_r            <= '0;
      dcnt_r         <= '0;
      found_r        <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      k_r         <= k_nxt;
      dcnt_r      <= dcnt_nxt;
      found_r     <= found_nxt;
      if (cfg_valid && cfg_ready) begin
        vertex_count_r <= cfg_data;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    ax_r       <= ax_nxt;
    ay_r       <= ay_nxt;
    bx_r       <= bx_nxt;
    by_r       <= by_nxt;
    ux_r       <= ux_nxt;
    uy_r       <= uy_nxt;
    wx_r       <= wx_nxt;
    wy_r       <= wy_nxt;
    dot_r      <= dot_nxt;
    uu_r       <= uu_nxt;
    rem_r      <= rem_nxt;
    q_r        <= q_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    best_r     <= best_nxt;
    dist_r     <= dist_nxt;
    out_data_r <= out_data_nxt;
  end

  // The root unit only reports while the sequencer waits for it.
  `PPD_ASSERT_IMP(a_sqrt_done_in_wait, sqrt_done, state_r == S_SQRT)
  // Every segment endpoint read lies inside the vertices in use.
  `PPD_ASSERT_IMP(a_read_in_range, state_r == S_LDB, NumWidth'(idx_r) < n_r)
  // The division remainder stays below the divisor.
  `PPD_ASSERT_IMP(a_div_rem_bound, state_r == S_DIV, rem_r < uu_ext)
  // A query transaction blocks further input in the next cycle.
  `PPD_ASSERT_NXT(a_query_busy, in_valid && in_ready && in_data.command == CMD_QUERY, !in_ready)

endmodule
`default_nettype wire

// File: rtl/core/ppd_sqrt.sv
`default_nettype none
module ppd_sqrt
  import ppd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [ACC_WIDTH-1:0]  radicand,
  output logic                       done,
  output logic [SQRT_STEPS-1:0]      root
);

  localparam int RadWidth = 2 * SQRT_STEPS;
  localparam int CntWidth = (SQRT_STEPS > 1) ? $clog2(SQRT_STEPS) : 1;

  logic [RadWidth-1:0]   rad_r, rad_nxt;
  logic [SQRT_STEPS:0]   rem_r, rem_nxt;
  logic [SQRT_STEPS-1:0] root_r, root_nxt;
  logic [CntWidth-1:0]   cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [SQRT_STEPS+2:0] rem_sh;
  logic [SQRT_STEPS+2:0] trial;
  logic                  ge;

  // One result bit per cycle: bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem_r, rad_r[RadWidth-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_comb begin
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = RadWidth'(radicand);
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt  = rad_r << 2;
      rem_nxt  = ge ? (SQRT_STEPS+1)'(rem_sh - trial) : rem_sh[SQRT_STEPS:0];
      root_nxt = {root_r[SQRT_STEPS-2:0], ge};
      cnt_nxt  = cnt_r + CntWidth'(1);
      if (cnt_r == CntWidth'(SQRT_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire
